@@ rtl/cidr_address_allow_filter_macros.svh @@
// Assertion macros used by the CIDR allow filter top level.
`ifndef CIDR_ADDRESS_ALLOW_FILTER_MACROS_SVH
`define CIDR_ADDRESS_ALLOW_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define CIDR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cidr filter: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define CIDR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cidr filter: next-cycle check failed");
`else
`define CIDR_ASSERT_IMP(label, clk, rst, ante, cons)
`define CIDR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cidr_pkg.sv @@
// Shared types and constants of the CIDR allow filter.
`default_nettype none
package cidr_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam int ADDR_W = 128;
  localparam int HALF_W = 64;
  localparam int PREFIX_W = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  localparam logic [PREFIX_W-1:0] MAX_PREFIX_V4 = 8'd32;
  localparam logic [PREFIX_W-1:0] MAX_PREFIX_V6 = 8'd128;

  // One stored range.
  typedef struct packed {
    logic [HALF_W-1:0]   addr_high;
    logic [HALF_W-1:0]   addr_low;
    logic [PREFIX_W-1:0] prefix;
    logic                family;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/cidr_address_allow_filter.sv @@
// Top level of the CIDR address allow filter: sequencer, table, compare unit and output register.
//
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  op, is_ipv6, address_high, address_low,
//                                           prefix_length
//  out      out        out_valid / out_stall allowed, rejected
//
// Clear, add and unused op: ST_EXEC does the work, then ST_RESP loads the result register.
// Check: an empty table goes the same way; else ST_SCAN runs between the two; the
//   single read port of the table steps one entry per cycle into the compare unit,
//   and the scan stops early on the first hit.
// Reset empties the table at once (entry_count to zero); no clearing pass.
// in_stall is high during reset and whenever a transaction is in work; a result
//   waiting under out_stall holds the block in its response state.
`default_nettype none
`include "cidr_address_allow_filter_macros.svh"
module cidr_address_allow_filter #(
  parameter int TABLE_DEPTH = cidr_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    op,
  input  wire logic                          is_ipv6,
  input  wire logic [cidr_pkg::HALF_W-1:0]   address_high,
  input  wire logic [cidr_pkg::HALF_W-1:0]   address_low,
  input  wire logic [cidr_pkg::PREFIX_W-1:0] prefix_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               allowed,
  output logic                               rejected
);
  import cidr_pkg::*;

  // count holds 0..TABLE_DEPTH, index holds 0..TABLE_DEPTH-1
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched transaction
  logic [1:0]          req_op;
  logic                req_family;
  logic [HALF_W-1:0]   req_high;
  logic [HALF_W-1:0]   req_low;
  logic [PREFIX_W-1:0] req_prefix;

  logic [CW-1:0] entry_count, count_next;
  logic [CW-1:0] scan_idx, scan_next;
  logic          cmp_valid, cmp_valid_next;
  logic          cmp_last, cmp_last_next;
  logic          res_allowed, res_allowed_next;
  logic          res_rejected, res_rejected_next;

  logic   wr_en;
  logic   rd_en;
  logic   load_out;
  logic   hit;
  logic   done_now;
  logic   too_long;
  logic   full;
  entry_t wr_data;
  entry_t rd_data;

  assign in_stall = rst || (state != ST_IDLE);

  assign too_long = req_family ? (req_prefix > MAX_PREFIX_V6) : (req_prefix > MAX_PREFIX_V4);
  assign full     = (entry_count == CW'(TABLE_DEPTH));
  assign wr_data  = '{addr_high: req_high, addr_low: req_low,
                      prefix: req_prefix, family: req_family};

  cidr_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IW-1:0]),
    .rd_data (rd_data)
  );

  cidr_match u_match (
    .entry      (rd_data),
    .key_high   (req_high),
    .key_low    (req_low),
    .key_family (req_family),
    .hit        (hit)
  );

  // scan ends on a hit or once the last issued entry has been compared
  assign done_now = cmp_valid && (hit || cmp_last);

  always_comb begin
    state_next        = state;
    count_next        = entry_count;
    scan_next         = scan_idx;
    cmp_valid_next    = 1'b0;
    cmp_last_next     = cmp_last;
    res_allowed_next  = res_allowed;
    res_rejected_next = res_rejected;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    load_out          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_allowed_next  = 1'b0;
        res_rejected_next = 1'b0;
        state_next        = ST_RESP;
        unique case (req_op)
          OP_CLEAR: begin
            count_next = '0;
          end
          OP_ADD: begin
            if (too_long || full) begin
              res_rejected_next = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = entry_count + CW'(1);
            end
          end
          OP_CHECK: begin
            if (entry_count == '0) begin
              res_allowed_next = 1'b1;
            end else begin
              scan_next  = '0;
              state_next = ST_SCAN;
            end
          end
          default: begin
            // unused op: no effect, both flags low
          end
        endcase
      end
      ST_SCAN: begin
        if (done_now) begin
          res_allowed_next = hit;
          state_next       = ST_RESP;
        end else if (scan_idx != entry_count) begin
          // read entry scan_idx; it is compared next cycle
          rd_en          = 1'b1;
          scan_next      = scan_idx + CW'(1);
          cmp_valid_next = 1'b1;
          cmp_last_next  = ((scan_idx + CW'(1)) == entry_count);
        end
      end
      ST_RESP: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      cmp_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      cmp_valid   <= cmp_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_op     <= op;
      req_family <= is_ipv6;
      req_high   <= address_high;
      req_low    <= address_low;
      req_prefix <= prefix_length;
    end
    scan_idx     <= scan_next;
    cmp_last     <= cmp_last_next;
    res_allowed  <= res_allowed_next;
    res_rejected <= res_rejected_next;
    if (load_out) begin
      allowed  <= res_allowed;
      rejected <= res_rejected;
    end
  end

  `CIDR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, entry_count <= CW'(TABLE_DEPTH))
  `CIDR_ASSERT_IMP(a_read_in_range, clk, rst, rd_en, scan_idx < entry_count)
  `CIDR_ASSERT_IMP(a_cmp_in_scan, clk, rst, cmp_valid, state == ST_SCAN)
  `CIDR_ASSERT_IMP(a_one_flag, clk, rst, out_valid, !(allowed && rejected))
  `CIDR_ASSERT_NXT(a_add_grows, clk, rst, wr_en, entry_count == $past(entry_count) + CW'(1))

endmodule
`default_nettype wire

@@ rtl/cidr_table.sv @@
// Range table storage: one write port, one registered read port.
`default_nettype none
module cidr_table #(
  parameter int TABLE_DEPTH = cidr_pkg::TABLE_DEPTH_DEFAULT,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_addr,
  input  wire cidr_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [IW-1:0]   rd_addr,
  output cidr_pkg::entry_t     rd_data
);
  import cidr_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/cidr_match.sv @@
// Prefix compare unit: family check plus masked 128-bit compare.
`default_nettype none
module cidr_match (
  input  wire cidr_pkg::entry_t             entry,
  input  wire logic [cidr_pkg::HALF_W-1:0]  key_high,
  input  wire logic [cidr_pkg::HALF_W-1:0]  key_low,
  input  wire logic                         key_family,
  output logic                              hit
);
  import cidr_pkg::*;

  logic [ADDR_W-1:0] entry_addr;
  logic [ADDR_W-1:0] key_addr;
  logic [ADDR_W-1:0] lead;

  assign entry_addr = {entry.addr_high, entry.addr_low};
  assign key_addr   = {key_high, key_low};
  // leading-ones mask; prefix of 128 shifts every one out
  assign lead = ~({ADDR_W{1'b1}} >> entry.prefix);
  assign hit  = (entry.family == key_family) && (((entry_addr ^ key_addr) & lead) == '0);

endmodule
`default_nettype wire
